// ----- rtl/core/pwcq_pkg.sv -----
package pwcq_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int WIDTH_BITS   = 16;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW_W         = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CNT_W        = 8;

    localparam logic [PW_W-1:0] PW_MASK = (WIDTH_BITS >= PW_W) ? {PW_W{1'b1}} :
                                          PW_W'((64'd1 << WIDTH_BITS) - 64'd1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [15:0] IDLE_MIN_RST  = 16'd10;
    localparam logic [15:0] IDLE_MAX_RST  = 16'd12;
    localparam logic [15:0] VALID_MIN_RST = 16'd18;
    localparam logic [15:0] VALID_MAX_RST = 16'd20;
    localparam logic [7:0]  ERR_LIMIT_RST = 8'd20;
    localparam logic [7:0]  HOLDOFF_RST   = 8'(1000 / 20);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_VALID = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_MIN  = 3'd0,
        CFG_IDLE_MAX  = 3'd1,
        CFG_VALID_MIN = 3'd2,
        CFG_VALID_MAX = 3'd3,
        CFG_ERR_LIMIT = 3'd4,
        CFG_HOLDOFF   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_WAIT = 2'd0,
        S_CALC = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic            edge_wr;
        logic            calc;
        logic [CH_W-1:0] idx;
        logic            last;
    } t_cmd;

endpackage

// ----- rtl/core/pwcq_ctrl.sv -----
module pwcq_ctrl
    import pwcq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_idx, n_idx;
    logic            w_last;
    logic            w_accept;

    assign w_last   = (r_idx == CH_W'(NUM_CHANNELS - 1));
    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_cmd.edge_wr = 1'b0;
        o_cmd.calc    = 1'b0;
        o_cmd.idx     = r_idx;
        o_cmd.last    = w_last;
        case (r_state)
            S_WAIT: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action) begin
                        n_state = S_CALC;
                        n_idx   = '0;
                    end else begin
                        o_cmd.edge_wr = 1'b1;
                    end
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (w_last) begin
                        n_state = S_WAIT;
                    end else begin
                        n_state = S_CALC;
                        n_idx   = r_idx + CH_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_calc_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CALC |=> r_state == S_OUT)
        else $error("result not presented after channel update");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_idx)))
        else $error("stalled result dropped");
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action) |=> (r_state == S_CALC && r_idx == '0))
        else $error("tick did not start at first channel");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
`endif

endmodule

// ----- rtl/core/pwcq_dp.sv -----
module pwcq_dp
    import pwcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_channel,
    input  logic [PW_W-1:0]       i_pulse_width,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_channel,
    output logic                  o_fire,
    output logic [1:0]            o_filtered_status,
    output logic                  o_raw_valid,
    output logic                  o_last_of_tick
);

    logic [15:0] r_idle_min, r_idle_max, r_valid_min, r_valid_max;
    logic [7:0]  r_err_limit, r_holdoff;

    t_status    r_raw   [NUM_CHANNELS];
    t_status    r_fprev [NUM_CHANNELS];
    logic [CNT_W-1:0] r_err  [NUM_CHANNELS];
    logic [CNT_W-1:0] r_hold [NUM_CHANNELS];

    logic            r_o_chan, r_o_fire, r_o_rawv, r_o_last;
    t_status         r_o_stat;

    logic [PW_W-1:0] w_pw;
    t_status         w_class;
    logic            w_chan_ok;
    logic [CH_W-1:0] w_edge_idx;

    t_status          w_raw, w_fp, w_cur;
    logic [CNT_W-1:0] w_ec, w_ec1, w_ec_n, w_hc, w_hc1, w_hc_n;
    logic             w_fire;

    assign w_pw       = i_pulse_width & PW_MASK;
    assign w_chan_ok  = (32'(i_channel) < NUM_CHANNELS);
    assign w_edge_idx = CH_W'(i_channel);

    always_comb begin
        if (w_pw >= r_idle_min && w_pw <= r_idle_max) begin
            w_class = ST_IDLE;
        end else if (w_pw >= r_valid_min && w_pw <= r_valid_max) begin
            w_class = ST_VALID;
        end else begin
            w_class = ST_ERROR;
        end
    end

    always_comb begin
        w_raw  = r_raw[i_cmd.idx];
        w_fp   = r_fprev[i_cmd.idx];
        w_ec   = r_err[i_cmd.idx];
        w_hc   = r_hold[i_cmd.idx];
        w_cur  = w_raw;
        w_ec1  = (w_ec == CNT_MAX) ? CNT_MAX : w_ec + CNT_W'(1);
        w_ec_n = '0;
        case (w_raw)
            ST_ERROR: begin
                if (w_ec1 <= r_err_limit) begin
                    w_cur  = w_fp;
                    w_ec_n = w_ec1;
                end else begin
                    w_cur  = ST_ERROR;
                    w_ec_n = '0;
                end
            end
            default: begin
                w_ec_n = '0;
            end
        endcase
        w_fire = (w_cur == ST_IDLE) && (w_fp == ST_VALID) && (w_hc >= r_holdoff);
        w_hc1  = w_fire ? '0 : w_hc;
        w_hc_n = (w_hc1 < r_holdoff) ? w_hc1 + CNT_W'(1) : r_holdoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_min  <= IDLE_MIN_RST;
            r_idle_max  <= IDLE_MAX_RST;
            r_valid_min <= VALID_MIN_RST;
            r_valid_max <= VALID_MAX_RST;
            r_err_limit <= ERR_LIMIT_RST;
            r_holdoff   <= HOLDOFF_RST;
        end else if (i_cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IDLE_MIN:  r_idle_min  <= i_cfg_data;
                CFG_IDLE_MAX:  r_idle_max  <= i_cfg_data;
                CFG_VALID_MIN: r_valid_min <= i_cfg_data;
                CFG_VALID_MAX: r_valid_max <= i_cfg_data;
                CFG_ERR_LIMIT: r_err_limit <= i_cfg_data[7:0];
                CFG_HOLDOFF:   r_holdoff   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_raw[c]   <= ST_IDLE;
                r_fprev[c] <= ST_IDLE;
                r_err[c]   <= '0;
                r_hold[c]  <= '0;
            end
        end else begin
            if (i_cmd.edge_wr && w_chan_ok) begin
                r_raw[w_edge_idx] <= w_class;
            end
            if (i_cmd.calc) begin
                r_fprev[i_cmd.idx] <= w_cur;
                r_err[i_cmd.idx]   <= w_ec_n;
                r_hold[i_cmd.idx]  <= w_hc_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_o_chan <= i_cmd.idx[0];
            r_o_fire <= w_fire;
            r_o_stat <= w_cur;
            r_o_rawv <= (w_raw == ST_VALID);
            r_o_last <= i_cmd.last;
        end
    end

    assign o_out_channel     = r_o_chan;
    assign o_fire            = r_o_fire;
    assign o_filtered_status = r_o_stat;
    assign o_raw_valid       = r_o_rawv;
    assign o_last_of_tick    = r_o_last;

endmodule

// ----- rtl/core/pulse_width_command_qualifier_unit.sv -----
// falling-edge item: accepted without a stall, no result, next item the cycle after
// tick item: one result per channel, each through an update state (S_CALC), then the output register (S_OUT)
// the first result is offered in S_OUT, after the S_CALC update of the first channel
// tick walks every channel through S_CALC and S_OUT, next item accepted the cycle after the last result
// input is stalled from tick accept until the last result of the tick is taken
// synchronous active-low reset: windows and limits to defaults, all channels idle, counts zero
module pulse_width_command_qualifier_unit
    import pwcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic                  i_channel,
    input  logic [PW_W-1:0]       i_pulse_width,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_out_channel,
    output logic                  o_fire,
    output logic [1:0]            o_filtered_status,
    output logic                  o_raw_valid,
    output logic                  o_last_of_tick,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    pwcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pwcq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_channel         (i_channel),
        .i_pulse_width     (i_pulse_width),
        .i_cfg_wr          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_channel     (o_out_channel),
        .o_fire            (o_fire),
        .o_filtered_status (o_filtered_status),
        .o_raw_valid       (o_raw_valid),
        .o_last_of_tick    (o_last_of_tick)
    );

endmodule
